[design/assert_macros.svh]
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ispb_pkg.sv]
`timescale 1ns / 1ps

package ispb_pkg;

    localparam int BUFFER_BYTES      = 64;
    localparam int NONVOLATILE_BYTES = 128;
    localparam int TOTAL_BYTES       = BUFFER_BYTES + NONVOLATILE_BYTES;

    // unified memory map: rx buffer, tx buffer, nonvolatile region
    localparam int RX_BASE   = 0;
    localparam int TX_BASE   = BUFFER_BYTES;
    localparam int NV_BASE   = 2 * BUFFER_BYTES;
    localparam int MEM_DEPTH = NV_BASE + NONVOLATILE_BYTES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int PTR_W  = 16;
    localparam int BYTE_W = 8;

    localparam logic [2:0] MODE_ADDR_WRITE = 3'd0;
    localparam logic [2:0] MODE_BYTE_RX    = 3'd1;
    localparam logic [2:0] MODE_BYTE_TX    = 3'd2;
    localparam logic [2:0] MODE_END        = 3'd3;
    localparam logic [2:0] MODE_TX_LOAD    = 3'd4;
    localparam logic [2:0] MODE_RX_READ    = 3'd5;

    typedef struct packed {
        logic [2:0]        mode;
        logic [BYTE_W-1:0] data_byte;
        logic [5:0]        host_index;
    } item_t;

    typedef struct packed {
        logic              ack;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

endpackage

[design/ispb_ram.sv]
`timescale 1ns / 1ps

module ispb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[design/i2c_slave_pointer_buffer.sv]
`timescale 1ns / 1ps
// Latency: a result word appears on the cycle after its command, strobed by done.
// Throughput: one command word per cycle; busy stays low, the single RAM port
//   carries at most one read or one write per word.
// Reset (rst_n, async, low): pointer invalid and zero, one-byte pointer mode,
//   every entry reads as unwritten at once via per-entry valid bits (nonvolatile erased, buffers zero).
// The receiver cannot stall: each result is shown for exactly one cycle.
module i2c_slave_pointer_buffer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ispb_pkg::item_t   item,
    output logic              done,
    output ispb_pkg::result_t result,
    input  logic              wr_en,
    input  logic              wr_data
);

    import ispb_pkg::*;

    // pointer states; code 3 is never entered but is handled as a reset path
    localparam logic [1:0] PS_INVALID  = 2'd0;
    localparam logic [1:0] PS_WAIT_LOW = 2'd1;
    localparam logic [1:0] PS_VALID    = 2'd2;

    localparam logic [PTR_W-1:0] BUF_PTR   = PTR_W'(BUFFER_BYTES);
    localparam logic [PTR_W-1:0] TOTAL_PTR = PTR_W'(TOTAL_BYTES);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(TOTAL_BYTES - 1);
    // pointer above the buffer maps onto the nonvolatile region
    localparam logic [PTR_W-1:0] NV_OFS    = PTR_W'(NV_BASE - BUFFER_BYTES);
    localparam logic [PTR_W-1:0] NV_PTR    = PTR_W'(NV_BASE);
    localparam logic [PTR_W-1:0] TX_PTR    = PTR_W'(TX_BASE);
    localparam logic [PTR_W-1:0] RX_PTR    = PTR_W'(RX_BASE);

    // control and configuration state
    logic             wide_reg;
    logic [1:0]       pstate_reg, pstate_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             done_reg;
    logic [MEM_DEPTH-1:0] valid_reg;

    // result payload, no reset needed
    logic ack_reg, ack_next;
    logic rd_reg, rd_next;
    logic hit_reg;
    logic erased_reg;

    // RAM access
    logic              mem_en, mem_we;
    logic [PTR_W-1:0]  mem_addr_w;
    logic [ADDR_W-1:0] mem_addr;
    logic [BYTE_W-1:0] mem_rdata;

    logic             accept;
    logic [PTR_W-1:0] host_ptr, data_ptr, rd_ptr, wl_ptr;
    logic             host_ok;
    logic [1:0]       rd_state;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign host_ptr = {{(PTR_W-6){1'b0}}, item.host_index};
    assign data_ptr = {{(PTR_W-BYTE_W){1'b0}}, item.data_byte};
    assign host_ok  = host_ptr < BUF_PTR;

    // read path: a half-built wide pointer is taken as its high byte alone
    assign rd_ptr   = (pstate_reg == PS_WAIT_LOW) ? (ptr_reg >> BYTE_W) : ptr_reg;
    assign rd_state = (pstate_reg == PS_WAIT_LOW && rd_ptr < TOTAL_PTR) ? PS_VALID
                                                                        : pstate_reg;
    // write path: low byte completes the wide pointer
    assign wl_ptr   = ptr_reg | data_ptr;

    always_comb
    begin
        pstate_next = pstate_reg;
        ptr_next    = ptr_reg;
        ack_next    = 1'b0;
        rd_next     = 1'b0;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr_w  = '0;
        if (accept)
        begin
            unique case (item.mode)
                MODE_ADDR_WRITE:
                begin
                    ptr_next    = '0;
                    pstate_next = PS_INVALID;
                    ack_next    = 1'b1;
                end
                MODE_BYTE_RX:
                begin
                    // default: drop the pointer and NACK
                    ptr_next    = '0;
                    pstate_next = PS_INVALID;
                    unique case (pstate_reg)
                        PS_INVALID:
                        begin
                            if (wide_reg)
                            begin
                                ptr_next    = {item.data_byte, {BYTE_W{1'b0}}};
                                pstate_next = PS_WAIT_LOW;
                                ack_next    = 1'b1;
                            end
                            else if (data_ptr < TOTAL_PTR)
                            begin
                                ptr_next    = data_ptr;
                                pstate_next = PS_VALID;
                                ack_next    = 1'b1;
                            end
                        end
                        PS_WAIT_LOW:
                        begin
                            if (wl_ptr < TOTAL_PTR)
                            begin
                                ptr_next    = wl_ptr;
                                pstate_next = PS_VALID;
                                ack_next    = 1'b1;
                            end
                        end
                        PS_VALID:
                        begin
                            if (ptr_reg < TOTAL_PTR)
                            begin
                                mem_en      = 1'b1;
                                mem_we      = 1'b1;
                                mem_addr_w  = (ptr_reg < BUF_PTR) ? ptr_reg + RX_PTR
                                                                  : ptr_reg + NV_OFS;
                                ptr_next    = ptr_reg + PTR_W'(1);
                                pstate_next = PS_VALID;
                                ack_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_BYTE_TX:
                begin
                    ptr_next    = rd_ptr;
                    pstate_next = rd_state;
                    if (rd_state == PS_VALID && rd_ptr < TOTAL_PTR)
                    begin
                        mem_en     = 1'b1;
                        mem_addr_w = (rd_ptr < BUF_PTR) ? rd_ptr + TX_PTR : rd_ptr + NV_OFS;
                        rd_next    = 1'b1;
                        ptr_next   = rd_ptr + PTR_W'(1);
                        // NACK marks the last byte of the space
                        ack_next   = rd_ptr < LAST_PTR;
                    end
                end
                MODE_END:
                begin
                    ack_next = 1'b1;
                end
                MODE_TX_LOAD:
                begin
                    if (host_ok)
                    begin
                        mem_en     = 1'b1;
                        mem_we     = 1'b1;
                        mem_addr_w = host_ptr + TX_PTR;
                        ack_next   = 1'b1;
                    end
                end
                MODE_RX_READ:
                begin
                    if (host_ok)
                    begin
                        mem_en     = 1'b1;
                        mem_addr_w = host_ptr + RX_PTR;
                        rd_next    = 1'b1;
                        ack_next   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign mem_addr = mem_addr_w[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b0;
            pstate_reg <= PS_INVALID;
            ptr_reg    <= '0;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wide_reg <= wr_data;
            end
            pstate_reg <= pstate_next;
            ptr_reg    <= ptr_next;
            done_reg   <= accept;
            // an entry holds real data once written
            if (mem_en && mem_we)
            begin
                valid_reg[mem_addr] <= 1'b1;
            end
        end
    end

    // a write lands in the RAM and valid bit at the same edge, so a read by the
    // very next word already sees it: no forwarding needed
    always_ff @(posedge clk)
    begin
        ack_reg    <= ack_next;
        rd_reg     <= rd_next;
        hit_reg    <= valid_reg[mem_addr];
        erased_reg <= mem_addr_w >= NV_PTR;
    end

    ispb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (item.data_byte),
        .rdata (mem_rdata)
    );

    // unwritten nonvolatile entries read erased, unwritten buffer entries zero
    assign done            = done_reg;
    assign result.ack      = ack_reg;
    assign result.out_byte = !rd_reg ? {BYTE_W{1'b0}}
                           : (hit_reg ? mem_rdata : {BYTE_W{erased_reg}});

endmodule

[design/ispb_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ispb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input ispb_pkg::item_t   item,
    input logic              done,
    input ispb_pkg::result_t result
);

    import ispb_pkg::*;

    `ASSERT_NEXT(a_word_answered, clk, rst_n, start && !busy, done, "accepted word not answered")
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !(start && !busy), !done, "result without a word")
    `ASSERT_NEXT(a_addr_write, clk, rst_n, start && !busy && item.mode == MODE_ADDR_WRITE,
        result.ack && result.out_byte == 8'h00, "address phase must ACK with zero byte")
    `ASSERT_NEXT(a_unused_mode, clk, rst_n, start && !busy && item.mode > MODE_RX_READ,
        !result.ack && result.out_byte == 8'h00, "unused mode must NACK with zero byte")
    `ASSERT_SAME(a_quiet_byte, clk, rst_n, done && !result.ack && result.out_byte != 8'h00,
        $past(item.mode) == MODE_BYTE_TX, "non-zero byte on NACK outside a bus read")

endmodule

bind i2c_slave_pointer_buffer ispb_checker u_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 1ps

// Bench for the EEPROM-style I2C slave byte engine.
//
// Decoded bus events and host accesses go in as command words. Each accepted
// word is run through a behavioural copy of the pointer logic and of the three
// byte stores kept here, and the answer that copy gives is queued. Every word
// strobed out by done is compared, field by field, against the oldest queued
// answer.
//
// Stimulus runs in this order:
//   - short directed tests for the pointer edge cases and the host side;
//   - random phases of mostly well-formed bus transactions, with the sender
//     idle rate and the pointer mode changing from one phase to the next.
// The receiver side has no stall input, so only the sender ever idles.
module testbench;

    import ispb_pkg::*;

    // Modes 6 and 7 carry no meaning; the block answers them with a NACK.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int RESET_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASE_WORDS  = 250;

    typedef enum logic [1:0] {
        PTR_INVALID,
        PTR_WAIT_LOW,
        PTR_VALID
    } ptr_state_t;

    logic    clk     = 1'b0;
    logic    rst_n   = 1'b0;
    logic    start   = 1'b0;
    logic    busy;
    item_t   item    = '0;
    logic    done;
    result_t result;
    logic    wr_en   = 1'b0;
    logic    wr_data = 1'b0;

    // Shadow copy of the slave: pointer, its state and the three stores.
    logic       shadow_wide;
    ptr_state_t shadow_state;
    logic [15:0] shadow_ptr;
    logic [7:0] rx_shadow [BUFFER_BYTES];
    logic [7:0] tx_shadow [BUFFER_BYTES];
    logic [7:0] nv_shadow [NONVOLATILE_BYTES];

    // Answers still owed by the block, oldest first.
    result_t owed_answers[$];

    int   mismatches = 0;
    int   words_sent = 0;
    int   idle_pct   = 0;   // chance, per hundred words, of a gap before the word
    logic stim_wide  = 1'b0; // pointer mode the stimulus believes is set

    i2c_slave_pointer_buffer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .wr_en   (wr_en),
        .wr_data (wr_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case a word is never accepted or an answer never shows.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------

    function automatic void clear_shadow();
        shadow_wide  = 1'b0;
        shadow_state = PTR_INVALID;
        shadow_ptr   = '0;
        for (int i = 0; i < BUFFER_BYTES; i++)
        begin
            rx_shadow[i] = 8'h00;
            tx_shadow[i] = 8'h00;
        end
        // nonvolatile region comes up erased
        for (int i = 0; i < NONVOLATILE_BYTES; i++)
        begin
            nv_shadow[i] = 8'hFF;
        end
    endfunction

    // A byte written by the bus master: pointer byte(s) first, then data.
    // Returns the ack; any refusal drops the pointer.
    function automatic logic store_byte(input logic [7:0] b);
        logic ok;
        ok = 1'b0;
        case (shadow_state)
            PTR_INVALID:
            begin
                if (shadow_wide)
                begin
                    shadow_ptr   = {b, 8'h00};
                    shadow_state = PTR_WAIT_LOW;
                    ok           = 1'b1;
                end
                else if (b < TOTAL_BYTES)
                begin
                    shadow_ptr   = 16'(b);
                    shadow_state = PTR_VALID;
                    ok           = 1'b1;
                end
            end
            PTR_WAIT_LOW:
            begin
                shadow_ptr = shadow_ptr | 16'(b);
                if (shadow_ptr < TOTAL_BYTES)
                begin
                    shadow_state = PTR_VALID;
                    ok           = 1'b1;
                end
            end
            PTR_VALID:
            begin
                if (shadow_ptr < BUFFER_BYTES)
                begin
                    rx_shadow[shadow_ptr] = b;
                    shadow_ptr++;
                    ok = 1'b1;
                end
                else if (shadow_ptr < TOTAL_BYTES)
                begin
                    nv_shadow[shadow_ptr - BUFFER_BYTES] = b;
                    shadow_ptr++;
                    ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (!ok)
        begin
            shadow_ptr   = '0;
            shadow_state = PTR_INVALID;
        end
        return ok;
    endfunction

    // A byte requested by the bus master. A half-set wide pointer is taken as
    // its high byte alone. ack drops on the last byte of the space.
    function automatic logic fetch_byte(output logic [7:0] ob);
        ob = 8'h00;
        if (shadow_state == PTR_WAIT_LOW)
        begin
            shadow_ptr = shadow_ptr >> 8;
            if (shadow_ptr < TOTAL_BYTES)
            begin
                shadow_state = PTR_VALID;
            end
        end
        if (shadow_state != PTR_VALID || shadow_ptr >= TOTAL_BYTES)
        begin
            return 1'b0;
        end
        if (shadow_ptr < BUFFER_BYTES)
        begin
            ob = tx_shadow[shadow_ptr];
        end
        else
        begin
            ob = nv_shadow[shadow_ptr - BUFFER_BYTES];
        end
        shadow_ptr++;
        return shadow_ptr < TOTAL_BYTES;
    endfunction

    function automatic result_t predict_answer(input item_t w);
        result_t    r;
        logic [7:0] ob;
        r = '0;
        case (w.mode)
            MODE_ADDR_WRITE:
            begin
                shadow_ptr   = '0;
                shadow_state = PTR_INVALID;
                r.ack        = 1'b1;
            end
            MODE_BYTE_RX:
            begin
                r.ack = store_byte(w.data_byte);
            end
            MODE_BYTE_TX:
            begin
                r.ack      = fetch_byte(ob);
                r.out_byte = ob;
            end
            MODE_END:
            begin
                r.ack = 1'b1;
            end
            MODE_TX_LOAD:
            begin
                if (w.host_index < BUFFER_BYTES)
                begin
                    tx_shadow[w.host_index] = w.data_byte;
                    r.ack = 1'b1;
                end
            end
            MODE_RX_READ:
            begin
                if (w.host_index < BUFFER_BYTES)
                begin
                    r.out_byte = rx_shadow[w.host_index];
                    r.ack      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor and checker
    // ------------------------------------------------------------------

    function automatic void flag(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // Everything is sampled at the rising edge, before the block's own
    // updates land, so the order of processes within the step is irrelevant.
    // A word accepted on this edge is queued before the done check, which
    // keeps the checker right even if an answer came out in the same cycle.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_shadow();
        end
        else
        begin
            if (wr_en)
            begin
                shadow_wide = wr_data;
            end
            if (start && !busy)
            begin
                owed_answers.push_back(predict_answer(item));
            end
            if (done)
            begin
                if (owed_answers.size() == 0)
                begin
                    flag($sformatf("answer word with none owed: ack %0b, byte %02h",
                                   result.ack, result.out_byte));
                end
                else
                begin
                    want = owed_answers.pop_front();
                    if (result.ack !== want.ack)
                    begin
                        flag($sformatf("ack mismatch: expected %0b, got %0b",
                                       want.ack, result.ack));
                    end
                    if (result.out_byte !== want.out_byte)
                    begin
                        flag($sformatf("out_byte mismatch: expected %02h, got %02h",
                                       want.out_byte, result.out_byte));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command word and hold it until the block takes it. start is
    // left high afterwards so back-to-back words need no second write of it
    // within one step; it only drops for a gap or a settle.
    task automatic send_word(input logic [2:0] mode, input logic [7:0] data,
                             input logic [5:0] idx);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= {mode, data, idx};
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    // Stop sending and wait for every owed answer, plus a short margin.
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (owed_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic set_wide(input logic v);
        settle();
        wr_en   <= 1'b1;
        wr_data <= v;
        @(posedge clk);
        wr_en     <= 1'b0;
        stim_wide  = v;
    endtask

    // Pointer bytes as the master sends them; high_only leaves a wide
    // pointer half set.
    task automatic send_pointer(input logic [15:0] p, input logic high_only);
        if (stim_wide)
        begin
            send_word(MODE_BYTE_RX, p[15:8], 6'($urandom));
            if (!high_only)
            begin
                send_word(MODE_BYTE_RX, p[7:0], 6'($urandom));
            end
        end
        else
        begin
            send_word(MODE_BYTE_RX, p[7:0], 6'($urandom));
        end
    endtask

    // Mostly in range, with a bias towards the end of the space and the
    // boundary between the buffer and the nonvolatile region.
    function automatic logic [15:0] pick_pointer();
        case ($urandom_range(9))
            0:       return stim_wide ? 16'($urandom_range(65535)) : 16'($urandom_range(255));
            1, 2:    return 16'(TOTAL_BYTES - $urandom_range(1, 3));
            3:       return 16'(BUFFER_BYTES - $urandom_range(1, 3));
            default: return 16'($urandom_range(TOTAL_BYTES - 1));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One-byte pointer: invalid-pointer read, out-of-range pointer, a data
    // write, then the last byte, reading past the end and writing past it.
    task automatic test_narrow_pointer();
        send_word(MODE_BYTE_TX, 8'h00, 6'h00);
        send_word(MODE_ADDR_WRITE, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'hFF, 6'h3F);
        send_word(MODE_ADDR_WRITE, 8'hFF, 6'h3F);
        send_word(MODE_BYTE_RX, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'h5A, 6'h15);
        send_word(MODE_ADDR_WRITE, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'(TOTAL_BYTES - 1), 6'h00);
        send_word(MODE_BYTE_TX, 8'h00, 6'h00);
        send_word(MODE_BYTE_TX, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'hA5, 6'h2A);
    endtask

    // Host port: tx loads at both ends of the buffer, an rx read at its start,
    // plus end-of-transfer and the spare modes.
    task automatic test_host_side();
        send_word(MODE_TX_LOAD, 8'hFF, 6'h00);
        send_word(MODE_TX_LOAD, 8'h00, 6'h3F);
        send_word(MODE_RX_READ, 8'hFF, 6'h00);
        send_word(MODE_END, 8'hFF, 6'h3F);
        send_word(MODE_SPARE_LO, 8'hFF, 6'h3F);
        send_word(MODE_SPARE_HI, 8'h00, 6'h00);
    endtask

    // Two-byte pointer: last byte of the space, a pointer beyond it, and a
    // read with only the high byte set (first out of range, then shifted to 0).
    task automatic test_wide_pointer();
        set_wide(1'b1);
        send_word(MODE_ADDR_WRITE, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'(TOTAL_BYTES - 1), 6'h00);
        send_word(MODE_BYTE_RX, 8'h3C, 6'h00);
        send_word(MODE_ADDR_WRITE, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'h01, 6'h00);
        send_word(MODE_BYTE_RX, 8'h00, 6'h00);
        send_word(MODE_ADDR_WRITE, 8'h00, 6'h00);
        send_word(MODE_BYTE_RX, 8'hC8, 6'h00);
        send_word(MODE_BYTE_TX, 8'h00, 6'h00);
        send_word(MODE_BYTE_TX, 8'h00, 6'h00);
    endtask

    // Random bus traffic: mostly write and read transactions with random
    // content, some host accesses and some noise words.
    task automatic test_random_phase(input logic wide, input int pct, input int count);
        int target;
        int kind;
        int n;
        set_wide(wide);
        idle_pct = pct;
        target   = words_sent + count;
        while (words_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 35)
            begin
                send_word(MODE_ADDR_WRITE, 8'($urandom), 6'($urandom));
                send_pointer(pick_pointer(), 1'b0);
                n = $urandom_range(1, 8);
                repeat (n) send_word(MODE_BYTE_RX, 8'($urandom), 6'($urandom));
                send_word(MODE_END, 8'($urandom), 6'($urandom));
            end
            else if (kind < 70)
            begin
                send_word(MODE_ADDR_WRITE, 8'($urandom), 6'($urandom));
                // now and then a wide pointer is left half set before reading
                send_pointer(pick_pointer(), $urandom_range(99) < 15);
                if ($urandom_range(1))
                begin
                    send_word(MODE_END, 8'($urandom), 6'($urandom));
                end
                n = $urandom_range(1, 8);
                repeat (n) send_word(MODE_BYTE_TX, 8'($urandom), 6'($urandom));
                send_word(MODE_END, 8'($urandom), 6'($urandom));
            end
            else if (kind < 80)
            begin
                send_word(MODE_TX_LOAD, 8'($urandom), 6'($urandom));
            end
            else if (kind < 88)
            begin
                send_word(MODE_RX_READ, 8'($urandom), 6'($urandom));
            end
            else
            begin
                send_word(3'($urandom), 8'($urandom), 6'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_narrow_pointer();
        test_host_side();
        test_wide_pointer();

        // sender idle rates 0, 47, 0 and 38 per hundred, pointer mode flipping
        test_random_phase(1'b0, 0, PHASE_WORDS);
        test_random_phase(1'b1, 47, PHASE_WORDS);
        test_random_phase(1'b0, 0, PHASE_WORDS);
        test_random_phase(1'b1, 38, PHASE_WORDS);

        settle();
        if (mismatches == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
